FILE: hdl/bps_pkg.sv
// Shared types and constants for the button power sequencer.
// Holds the phase encoding, the pin level struct and the register map.
// No dependencies.
package bps_pkg;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_CFG   = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ON_DELAY_A    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ON_DELAY_B    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_DELAY_A   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_DELAY_B   = 3'd4;

  localparam logic [CFG_W-1:0] CFG_RESET [NUM_CFG] = '{
    16'd10, 16'd100, 16'd500, 16'd100, 16'd50
  };

  typedef enum logic [2:0] {
    PH_OFF  = 3'd0,
    PH_ON   = 3'd1,
    PH_UP_A = 3'd2,
    PH_UP_B = 3'd3,
    PH_DN_A = 3'd4,
    PH_DN_B = 3'd5
  } phase_t;

  typedef struct packed {
    logic rst;   // 0 reset asserted, 1 released
    logic r24;   // 0 shut down, 1 running
    logic r3;    // 1 shut down, 0 running
  } pins_t;

  localparam pins_t PINS_RESET = '{rst: 1'b0, r24: 1'b0, r3: 1'b1};

  function automatic logic is_busy(input phase_t ph);
    return (ph == PH_UP_A) || (ph == PH_UP_B) || (ph == PH_DN_A) || (ph == PH_DN_B);
  endfunction

  function automatic logic is_powered(input phase_t ph);
    return (ph == PH_ON) || (ph == PH_DN_A) || (ph == PH_DN_B);
  endfunction

endpackage

FILE: hdl/bps_cfg_regs.sv
// Configuration register file of the button power sequencer.
// Depends on bps_pkg for the register map and reset values.
module bps_cfg_regs
  import bps_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]                   cfg_index,
  input  logic [CFG_W-1:0]                       cfg_data,
  output logic [NUM_CFG-1:0][COUNT_WIDTH-1:0]    cfg_vals
);

  localparam int EXT_W = COUNT_WIDTH + CFG_W;

  logic [CFG_W-1:0] cfg_r [NUM_CFG];

  assign cfg_ready = 1'b1;

  for (genvar i = 0; i < NUM_CFG; i++) begin : g_reg
    logic [EXT_W-1:0] ext;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cfg_r[i] <= CFG_RESET[i];
      end else if (cfg_valid && (cfg_index == CFG_IDX_W'(i))) begin
        cfg_r[i] <= cfg_data;
      end
    end

    // Values are zero extended, then cut to the counter width.
    assign ext         = {{COUNT_WIDTH{1'b0}}, cfg_r[i]};
    assign cfg_vals[i] = ext[COUNT_WIDTH-1:0];
  end

endmodule

FILE: hdl/bps_step.sv
// Next-state logic of the button power sequencer for one tick.
// Depends on bps_pkg for the phase and pin types.
module bps_step
  import bps_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic [NUM_CFG-1:0][COUNT_WIDTH-1:0] cfg_vals,
  input  logic                                button_level,
  input  phase_t                              phase_i,
  input  pins_t                               pins_i,
  input  logic [COUNT_WIDTH-1:0]              delay_i,
  input  logic [COUNT_WIDTH-1:0]              sample_i,
  input  logic                                btn_now_i,
  output phase_t                              phase_o,
  output pins_t                               pins_o,
  output logic [COUNT_WIDTH-1:0]              delay_o,
  output logic [COUNT_WIDTH-1:0]              sample_o,
  output logic                                btn_now_o
);

  typedef struct packed {
    phase_t                 ph;
    pins_t                  pins;
    logic [COUNT_WIDTH-1:0] dc;
    logic [COUNT_WIDTH-1:0] sc;
  } seq_t;

  logic [COUNT_WIDTH-1:0] sample_period, on_a, on_b, off_a, off_b;

  assign sample_period = cfg_vals[CFG_SAMPLE_PERIOD];
  assign on_a          = cfg_vals[CFG_ON_DELAY_A];
  assign on_b          = cfg_vals[CFG_ON_DELAY_B];
  assign off_a         = cfg_vals[CFG_OFF_DELAY_A];
  assign off_b         = cfg_vals[CFG_OFF_DELAY_B];

  // One sequence action, taken only when the pending wait has run out.
  function automatic seq_t adv(input seq_t s_in);
    seq_t s;
    s = s_in;
    if (s.dc == '0) begin
      case (s.ph)
        PH_UP_A: begin
          s.pins.r24 = 1'b1;
          s.ph       = PH_UP_B;
          s.dc       = on_b;
        end
        PH_UP_B: begin
          s.pins.rst = 1'b1;
          s.ph       = PH_ON;
          s.sc       = '0;
        end
        PH_DN_A: begin
          s.pins.r24 = 1'b0;
          s.ph       = PH_DN_B;
          s.dc       = off_b;
        end
        PH_DN_B: begin
          s.pins.r3 = 1'b1;
          s.ph      = PH_OFF;
          s.sc      = '0;
        end
        default: begin
        end
      endcase
    end
    return s;
  endfunction

  seq_t s;
  logic on;

  always_comb begin
    s         = '{ph: phase_i, pins: pins_i, dc: delay_i, sc: sample_i};
    btn_now_o = btn_now_i;
    on        = (phase_i == PH_ON);
    if (is_busy(phase_i)) begin
      if (s.dc != '0) begin
        s.dc = s.dc - COUNT_WIDTH'(1);
      end
      // A tick can finish at most two chained zero-length waits.
      s = adv(s);
      s = adv(s);
    end else begin
      if (!on) begin
        s.ph = PH_OFF;
      end
      if (s.sc == '0) begin
        s.sc      = (sample_period == '0) ? '0 : sample_period - COUNT_WIDTH'(1);
        btn_now_o = button_level;
        if (!btn_now_i && button_level) begin
          if (on) begin
            s.pins.rst = 1'b0;
            s.ph       = PH_DN_A;
            s.dc       = off_a;
          end else begin
            s.pins.r3 = 1'b0;
            s.ph      = PH_UP_A;
            s.dc      = on_a;
          end
          s = adv(s);
          s = adv(s);
        end
      end else begin
        s.sc = s.sc - COUNT_WIDTH'(1);
      end
    end
  end

  assign phase_o  = s.ph;
  assign pins_o   = s.pins;
  assign delay_o  = s.dc;
  assign sample_o = s.sc;

endmodule

FILE: hdl/button_power_sequencer_core.sv
// Top level of the button power sequencer: state and result registers.
// Depends on bps_pkg, bps_cfg_regs and bps_step.
//
// Each accepted tick word carries the raw button level; each one yields exactly one
// result word with the reset, 24 V and 3 V pin levels, the powered flag and the busy
// flag as they stand after that tick. A tick is taken every clock cycle as long as
// results are taken: the sequencer state is updated by one pass of next-state logic at
// acceptance and the result goes to an output register. A result left waiting holds off
// the input, and the next tick is accepted in the same cycle that the result is taken.
// The result is registered and is valid in the cycle after acceptance. While idle the button is
// sampled every sample_period ticks (zero counts as one) and a rising edge between two
// samples starts a power-up or power-down; the button is ignored while one runs.
// Delay and period registers take effect at the start of the next wait or interval and
// are truncated to COUNT_WIDTH bits. The configuration port is always ready.
module button_power_sequencer_core
  import bps_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_button_level,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_reset_pin,
  output logic                 out_rail24_pin,
  output logic                 out_rail3_pin,
  output logic                 out_powered,
  output logic                 out_busy_res,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [NUM_CFG-1:0][COUNT_WIDTH-1:0] cfg_vals;

  phase_t                 phase_r, phase_nxt;
  pins_t                  pins_r, pins_nxt;
  logic [COUNT_WIDTH-1:0] delay_r, delay_nxt;
  logic [COUNT_WIDTH-1:0] sample_r, sample_nxt;
  logic                   btn_now_r, btn_now_nxt;
  logic                   out_valid_r;
  pins_t                  out_pins_r;
  logic                   out_powered_r, out_busy_r;
  logic                   in_fire;

  bps_cfg_regs #(.COUNT_WIDTH(COUNT_WIDTH)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_vals  (cfg_vals)
  );

  bps_step #(.COUNT_WIDTH(COUNT_WIDTH)) u_step (
    .cfg_vals     (cfg_vals),
    .button_level (in_button_level),
    .phase_i      (phase_r),
    .pins_i       (pins_r),
    .delay_i      (delay_r),
    .sample_i     (sample_r),
    .btn_now_i    (btn_now_r),
    .phase_o      (phase_nxt),
    .pins_o       (pins_nxt),
    .delay_o      (delay_nxt),
    .sample_o     (sample_nxt),
    .btn_now_o    (btn_now_nxt)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_OFF;
      pins_r      <= PINS_RESET;
      delay_r     <= '0;
      sample_r    <= '0;
      btn_now_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      phase_r     <= phase_nxt;
      pins_r      <= pins_nxt;
      delay_r     <= delay_nxt;
      sample_r    <= sample_nxt;
      btn_now_r   <= btn_now_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_pins_r    <= pins_nxt;
      out_powered_r <= is_powered(phase_nxt);
      out_busy_r    <= is_busy(phase_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_reset_pin  = out_pins_r.rst;
  assign out_rail24_pin = out_pins_r.r24;
  assign out_rail3_pin  = out_pins_r.r3;
  assign out_powered    = out_powered_r;
  assign out_busy_res   = out_busy_r;

`ifndef ASSERT_OFF
  // The 3 V rail comes up first, so with it shut down nothing else may run.
  a_rail3_first: assert property (@(posedge clk) disable iff (!rst_n)
    pins_r.r3 |-> (!pins_r.r24 && !pins_r.rst))
    else $error("24 V rail or reset released while 3 V rail is shut down");

  // Reset is released only with both rails running.
  a_reset_last: assert property (@(posedge clk) disable iff (!rst_n)
    pins_r.rst |-> (pins_r.r24 && !pins_r.r3))
    else $error("reset released before both rails run");

  // A pending wait exists only inside a sequence.
  a_delay_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (delay_r != '0) |-> is_busy(phase_r))
    else $error("delay counter running outside a sequence");

  // The result register shows the state taken at the last accepted tick.
  a_out_match: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (out_valid && (out_pins_r == pins_r) && (out_busy_res == is_busy(phase_r))))
    else $error("result word does not match sequencer state");
`endif

endmodule
